// File: hdl/drd_pkg.sv
// ---------------------------------------------------------------------------
// drd_pkg
// shared constants, types and helper functions of the detection row decoder
// ---------------------------------------------------------------------------
package drd_pkg;

   localparam int MAX_ROW_LENGTH  = 1024;
   localparam int COORD_LIMIT     = 8192;
   localparam int MIN_ROW_LENGTH  = 5;
   localparam int BOX_ELEMS       = 4;

   localparam int ROWREG_W   = 11;
   localparam int NCLS_W     = 10;
   localparam int THR_W      = 17;
   localparam int SCALE_W    = 25;
   localparam int IMGREG_W   = 14;
   localparam int ELEM_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   localparam int LEFT_W  = 13;
   localparam int TOP_W   = 13;
   localparam int BW_W    = 14;
   localparam int BH_W    = 14;
   localparam int CLS_W   = 10;
   localparam int SCORE_W = 31;
   localparam int RSP_W   = 96;
   localparam int RSP_PAD = RSP_W - (LEFT_W + TOP_W + BW_W + BH_W + CLS_W + SCORE_W);

   localparam int CNT_W  = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W  = $clog2(MAX_ROW_LENGTH + 1);
   localparam int IMG_W  = $clog2(COORD_LIMIT + 1);
   localparam int LCMP_W = (LEN_W > ROWREG_W) ? LEN_W : ROWREG_W;
   localparam int NCMP_W = (LEN_W > NCLS_W) ? LEN_W : NCLS_W;
   localparam int ICMP_W = (IMG_W > IMGREG_W) ? IMG_W : IMGREG_W;

   // 2c - d carries one extra fraction bit
   localparam int DIFF_W     = ELEM_W + 2;
   localparam int EDGE_P_W   = DIFF_W + SCALE_W + 1;
   localparam int SPAN_P_W   = ELEM_W + SCALE_W + 1;
   localparam int EDGE_SHIFT = 33;
   localparam int SPAN_SHIFT = 32;
   localparam int EDGE_W     = EDGE_P_W - EDGE_SHIFT;
   localparam int SPAN_W     = SPAN_P_W - SPAN_SHIFT;
   localparam int DIM_W      = ((EDGE_W + 1) > SPAN_W) ? (EDGE_W + 1) : SPAN_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_LENGTH     = 3'd0,
      REG_NUM_CLASSES    = 3'd1,
      REG_CONF_THRESHOLD = 3'd2,
      REG_SCALE_FACTOR   = 3'd3,
      REG_IMAGE_WIDTH    = 3'd4,
      REG_IMAGE_HEIGHT   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]   row_len;
      logic [NCLS_W-1:0]  num_cls;
      logic [THR_W-1:0]   threshold;
      logic [SCALE_W-1:0] scale;
      logic [IMG_W-1:0]   img_w;
      logic [IMG_W-1:0]   img_h;
   } cfg_type;

   typedef struct packed {
      logic signed [EDGE_P_W-1:0] edge_x;
      logic signed [EDGE_P_W-1:0] edge_y;
      logic signed [SPAN_P_W-1:0] span_w;
      logic signed [SPAN_P_W-1:0] span_h;
      logic signed [ELEM_W-1:0]   score;
      logic [CLS_W-1:0]           cls;
   } row_end_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [ROWREG_W-1:0] raw);
      logic [LCMP_W-1:0] r;
      r = LCMP_W'(raw);
      if (r < LCMP_W'(MIN_ROW_LENGTH)) begin
         r = LCMP_W'(MIN_ROW_LENGTH);
      end else if (r > LCMP_W'(MAX_ROW_LENGTH)) begin
         r = LCMP_W'(MAX_ROW_LENGTH);
      end
      return LEN_W'(r);
   endfunction

   function automatic logic [NCLS_W-1:0] clamp_ncls(input logic [NCLS_W-1:0] raw,
                                                     input logic [LEN_W-1:0]  len);
      logic [NCMP_W-1:0] n;
      logic [NCMP_W-1:0] hi;
      n  = NCMP_W'(raw);
      hi = NCMP_W'(len) - NCMP_W'(BOX_ELEMS);
      if (n == NCMP_W'(0)) begin
         n = NCMP_W'(1);
      end else if (n > hi) begin
         n = hi;
      end
      return NCLS_W'(n);
   endfunction

   function automatic logic [IMG_W-1:0] clamp_img(input logic [IMGREG_W-1:0] raw);
      logic [ICMP_W-1:0] r;
      r = ICMP_W'(raw);
      if (r == ICMP_W'(0)) begin
         r = ICMP_W'(1);
      end else if (r > ICMP_W'(COORD_LIMIT)) begin
         r = ICMP_W'(COORD_LIMIT);
      end
      return IMG_W'(r);
   endfunction

endpackage

// File: hdl/drd_csr.sv
// ---------------------------------------------------------------------------
// drd_csr
// configuration registers of the row decoder with range clamping
// ---------------------------------------------------------------------------
module drd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [drd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [drd_pkg::CSR_DATA_W-1:0]  csr_data,
   output drd_pkg::cfg_type                cfg
);
   import drd_pkg::*;

   logic [ROWREG_W-1:0] row_length_ff;
   logic [NCLS_W-1:0]   num_classes_ff;
   logic [THR_W-1:0]    conf_threshold_ff;
   logic [SCALE_W-1:0]  scale_factor_ff;
   logic [IMGREG_W-1:0] image_width_ff;
   logic [IMGREG_W-1:0] image_height_ff;
   logic [LEN_W-1:0]    len_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff     <= ROWREG_W'(116);
         num_classes_ff    <= NCLS_W'(80);
         conf_threshold_ff <= THR_W'(16384);
         scale_factor_ff   <= SCALE_W'(65536);
         image_width_ff    <= IMGREG_W'(640);
         image_height_ff   <= IMGREG_W'(640);
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROW_LENGTH:     row_length_ff     <= csr_data[ROWREG_W-1:0];
            REG_NUM_CLASSES:    num_classes_ff    <= csr_data[NCLS_W-1:0];
            REG_CONF_THRESHOLD: conf_threshold_ff <= csr_data[THR_W-1:0];
            REG_SCALE_FACTOR:   scale_factor_ff   <= csr_data[SCALE_W-1:0];
            REG_IMAGE_WIDTH:    image_width_ff    <= csr_data[IMGREG_W-1:0];
            REG_IMAGE_HEIGHT:   image_height_ff   <= csr_data[IMGREG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      len_in        = clamp_len(row_length_ff);
      cfg.row_len   = len_in;
      cfg.num_cls   = clamp_ncls(num_classes_ff, len_in);
      cfg.threshold = conf_threshold_ff;
      cfg.scale     = scale_factor_ff;
      cfg.img_w     = clamp_img(image_width_ff);
      cfg.img_h     = clamp_img(image_height_ff);
   end

endmodule

// File: hdl/drd_row.sv
// ---------------------------------------------------------------------------
// drd_row
// row position counter, box capture, running argmax and scale multiplies
// ---------------------------------------------------------------------------
module drd_row (
   input  logic                         clock,
   input  logic                         reset,
   input  drd_pkg::cfg_type             cfg,
   input  logic                         elem_accept,
   input  logic [drd_pkg::ELEM_W-1:0]   elem_value,
   output logic                         is_last,
   output logic                         end_valid,
   input  logic                         end_take,
   output drd_pkg::row_end_type         end_data
);
   import drd_pkg::*;

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic signed [ELEM_W-1:0]  box_ff [BOX_ELEMS];
   logic signed [ELEM_W-1:0]  best_ff;
   logic signed [ELEM_W-1:0]  best_in;
   logic [CLS_W-1:0]          cls_ff;
   logic [CLS_W-1:0]          cls_in;
   logic                      end_valid_ff;
   row_end_type               end_ff;
   row_end_type               end_in;

   logic signed [ELEM_W-1:0]  v;
   logic                      in_box;
   logic                      in_cls;
   logic [CNT_W-1:0]          k;
   logic                      take_best;
   logic signed [DIFF_W-1:0]  dx;
   logic signed [DIFF_W-1:0]  dy;
   logic signed [SCALE_W:0]   s_s;

   always_comb begin
      v         = signed'(elem_value);
      is_last   = LEN_W'(count_ff) >= (cfg.row_len - LEN_W'(1));
      in_box    = LEN_W'(count_ff) < LEN_W'(BOX_ELEMS);
      k         = count_ff - CNT_W'(BOX_ELEMS);
      in_cls    = !in_box && (NCMP_W'(k) < NCMP_W'(cfg.num_cls));
      take_best = in_cls && ((k == CNT_W'(0)) || (v > best_ff));
      best_in   = take_best ? v : best_ff;
      cls_in    = take_best ? CLS_W'(k) : cls_ff;
      count_in  = is_last ? CNT_W'(0) : (count_ff + CNT_W'(1));

      // products from the stored box, scale as a positive signed operand
      s_s = signed'({1'b0, cfg.scale});
      dx  = (DIFF_W'(box_ff[0]) <<< 1) - DIFF_W'(box_ff[2]);
      dy  = (DIFF_W'(box_ff[1]) <<< 1) - DIFF_W'(box_ff[3]);
      end_in.edge_x = EDGE_P_W'(dx) * EDGE_P_W'(s_s);
      end_in.edge_y = EDGE_P_W'(dy) * EDGE_P_W'(s_s);
      end_in.span_w = SPAN_P_W'(box_ff[2]) * SPAN_P_W'(s_s);
      end_in.span_h = SPAN_P_W'(box_ff[3]) * SPAN_P_W'(s_s);
      end_in.score  = best_in;
      end_in.cls    = cls_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         best_ff      <= '0;
         cls_ff       <= '0;
         end_valid_ff <= 1'b0;
      end else begin
         if (elem_accept) begin
            count_ff <= count_in;
            best_ff  <= best_in;
            cls_ff   <= cls_in;
         end
         if (elem_accept && is_last) begin
            end_valid_ff <= 1'b1;
         end else if (end_take) begin
            end_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (elem_accept && in_box) begin
         box_ff[count_ff[1:0]] <= v;
      end
      if (elem_accept && is_last) begin
         end_ff <= end_in;
      end
   end

   assign end_valid = end_valid_ff;
   assign end_data  = end_ff;

endmodule

// File: hdl/drd_box.sv
// ---------------------------------------------------------------------------
// drd_box
// truncation, image clamping, keep decision and result register
// ---------------------------------------------------------------------------
module drd_box (
   input  logic                        clock,
   input  logic                        reset,
   input  drd_pkg::cfg_type            cfg,
   input  logic                        end_valid,
   output logic                        end_take,
   input  drd_pkg::row_end_type        end_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [drd_pkg::RSP_W-1:0]   rsp_tdata
);
   import drd_pkg::*;

   logic                       rsp_valid_ff;
   logic [RSP_W-1:0]           rsp_data_ff;
   logic [RSP_W-1:0]           rsp_data_in;

   logic signed [EDGE_W-1:0]   left_raw;
   logic signed [EDGE_W-1:0]   top_raw;
   logic signed [DIM_W-1:0]    left_c;
   logic signed [DIM_W-1:0]    top_c;
   logic signed [DIM_W-1:0]    span_w;
   logic signed [DIM_W-1:0]    span_h;
   logic signed [DIM_W-1:0]    room_w;
   logic signed [DIM_W-1:0]    room_h;
   logic signed [DIM_W-1:0]    w_fin;
   logic signed [DIM_W-1:0]    h_fin;
   logic signed [ELEM_W-1:0]   thr_s;
   logic                       keep;

   always_comb begin
      // floor shift is enough: negative edges clamp to zero, negative spans drop
      left_raw = end_data.edge_x[EDGE_P_W-1:EDGE_SHIFT];
      top_raw  = end_data.edge_y[EDGE_P_W-1:EDGE_SHIFT];
      span_w   = DIM_W'(signed'(end_data.span_w[SPAN_P_W-1:SPAN_SHIFT]));
      span_h   = DIM_W'(signed'(end_data.span_h[SPAN_P_W-1:SPAN_SHIFT]));
      left_c   = (left_raw < 0) ? '0 : DIM_W'(left_raw);
      top_c    = (top_raw < 0) ? '0 : DIM_W'(top_raw);
      room_w   = signed'(DIM_W'(cfg.img_w)) - left_c;
      room_h   = signed'(DIM_W'(cfg.img_h)) - top_c;
      w_fin    = (room_w < span_w) ? room_w : span_w;
      h_fin    = (room_h < span_h) ? room_h : span_h;
      thr_s    = signed'(ELEM_W'(cfg.threshold));
      keep     = (end_data.score >= thr_s) &&
                 (w_fin > DIM_W'(1)) && (h_fin > DIM_W'(1));
      rsp_data_in = {{RSP_PAD{1'b0}},
                     end_data.score[SCORE_W-1:0],
                     end_data.cls,
                     h_fin[BH_W-1:0],
                     w_fin[BW_W-1:0],
                     top_c[TOP_W-1:0],
                     left_c[LEFT_W-1:0]};
      end_take = end_valid && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (end_take) begin
         rsp_valid_ff <= keep;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (end_take && keep) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/detection_row_decode.sv
// ---------------------------------------------------------------------------
// detection_row_decode
// decodes detector output rows streamed one element per word into boxes
//
//   channel  dir  words                       handshake
//   req_     in   one signed row element      tvalid / tready
//   rsp_     out  one kept box                tvalid / tready
//   csr_     in   register index and value    valid / ready (always ready)
//
// one element word is taken per cycle while req_tready is high; at a row end
// its scale products are registered, then clamped into the result register
// reset is synchronous and clears the row position, argmax and valid flags
// a waiting box holds off only the last element of the next row; all other
// elements keep flowing while rsp_ is stalled
// ---------------------------------------------------------------------------
module detection_row_decode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // element_value
   input  logic [drd_pkg::ELEM_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // box_left, box_top, box_width, box_height, class_index, best_score, zero pad
   output logic [drd_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [drd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [drd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import drd_pkg::*;

   cfg_type     cfg;
   row_end_type end_data;
   logic        end_valid;
   logic        end_take;
   logic        is_last;
   logic        elem_accept;

   assign req_tready  = !(is_last && end_valid);
   assign elem_accept = req_tvalid && req_tready;

   drd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   drd_row u_row (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .elem_accept (elem_accept),
      .elem_value  (req_tdata),
      .is_last     (is_last),
      .end_valid   (end_valid),
      .end_take    (end_take),
      .end_data    (end_data)
   );

   drd_box u_box (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .end_valid  (end_valid),
      .end_take   (end_take),
      .end_data   (end_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
